/* hw/rtl/lksm_pkg.sv */
`default_nettype none

package lksm_pkg;

  // table geometry
  localparam int SLOTS      = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W     = SLOT_W;
  localparam int KEY_W      = 8;
  localparam int SLOT_OUT_W = 6;

  // key held by slot 0 after reset; slot i holds KEY_BASE + i
  localparam int KEY_BASE = 48;

  // request kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;   // capture the request fields
    logic execute;    // compare, update table, load result register
  } lksm_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/lksm_ctrl.sv */
`default_nettype none

module lksm_ctrl
  import lksm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output lksm_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   rsp_free;

  assign req_stall    = (state != ST_IDLE);
  assign rsp_free     = !rsp_valid || !rsp_stall;
  assign cmd.load_req = (state == ST_IDLE) && req_valid;
  assign cmd.execute  = (state == ST_EXEC) && rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_EXEC;
          end
          if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (rsp_free) begin
            state     <= ST_IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result appears only from an execute cycle
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.execute))
    else $error("result valid without execute");

  // an accepted request is always held for execution
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> (state == ST_EXEC))
    else $error("accepted request not held for execution");

  // execute never overwrites a result still stalled downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> !(rsp_valid && rsp_stall))
    else $error("result register overwritten");

endmodule

`default_nettype wire

/* hw/rtl/lksm_dp.sv */
`default_nettype none

module lksm_dp
  import lksm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lksm_cmd_t        cmd,
  input  wire logic             kind,
  input  wire logic [KEY_W-1:0] key,
  output logic                  hit,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  evicted,
  output logic [KEY_W-1:0]      evicted_key
);

  logic [KEY_W-1:0]  keys  [SLOTS];
  logic [RANK_W-1:0] ranks [SLOTS];
  logic [RANK_W-1:0] ranks_next [SLOTS];

  logic              req_kind;
  logic [KEY_W-1:0]  req_key;

  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  lru_vec;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] victim;
  logic [SLOT_W-1:0] tgt;
  logic [RANK_W-1:0] tgt_rank;
  logic              any_match;
  logic              ins_miss;
  logic              do_touch;

  // parallel compare and LRU detect; lowest slot wins
  always_comb begin
    hit_idx = '0;
    victim  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      match[i]   = (keys[i] == req_key);
      lru_vec[i] = (ranks[i] == RANK_W'(SLOTS - 1));
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (lru_vec[i]) begin
        victim = SLOT_W'(i);
      end
    end
  end

  assign any_match = |match;
  assign ins_miss  = !any_match && (req_kind == KIND_INSERT);
  assign do_touch  = (any_match && (req_kind == KIND_LOOKUP)) || ins_miss;
  assign tgt       = any_match ? hit_idx : victim;
  assign tgt_rank  = ranks[tgt];

  // age every slot more recent than the target, target becomes rank 0
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (SLOT_W'(i) == tgt) begin
        ranks_next[i] = '0;
      end else if (ranks[i] < tgt_rank) begin
        ranks_next[i] = RANK_W'(ranks[i] + 1'b1);
      end else begin
        ranks_next[i] = ranks[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        keys[i]  <= KEY_W'(KEY_BASE + i);
        ranks[i] <= RANK_W'(i);
      end
    end else if (cmd.execute) begin
      if (do_touch) begin
        ranks <= ranks_next;
      end
      if (ins_miss) begin
        keys[victim] <= req_key;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind <= kind;
      req_key  <= key;
    end
    if (cmd.execute) begin
      hit         <= any_match;
      slot        <= (any_match || ins_miss) ? SLOT_OUT_W'(tgt) : '0;
      evicted     <= ins_miss;
      evicted_key <= ins_miss ? keys[victim] : '0;
    end
  end

  // exactly one least recent slot: ranks stay a permutation
  a_one_lru: assert property (@(posedge clk) disable iff (rst)
    $onehot(lru_vec))
    else $error("recency ranks lost uniqueness");

  // keys stay unique
  a_unique_keys: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("duplicate key in table");

  // touched slot becomes most recent
  a_touch_mru: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && do_touch) |=> (ranks[$past(tgt)] == '0))
    else $error("touched slot not most recent");

endmodule

`default_nettype wire

/* hw/rtl/lru_key_slot_map_unit.sv */
`default_nettype none

// Fully associative key-to-slot table of SLOTS entries (lksm_pkg) kept in
// least-recently-used order. A lookup (kind 0) returns the slot of a stored
// key and makes it most recent; a miss returns hit 0, slot 0 and leaves the
// table alone. An insert (kind 1) of a present key returns its slot and
// changes nothing; an insert of a new key evicts the least recent slot,
// returns that slot, evicted 1 and the key it held. After reset slot i holds
// key 48+i, slot 0 most recent and the last slot least recent.
// Each request transaction is first captured into the request register,
// then executed: all keys are compared in parallel and keys, ranks and the
// result register are updated together. A request is taken only while no other
// request waits to execute; a result held by rsp_stall delays the execute
// cycle of the next request but not its capture. No clearing pass after reset.

module lru_key_slot_map_unit
  import lksm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic                  kind,
  input  wire logic [KEY_W-1:0]      key,
  // result channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output logic                       hit,
  output logic [SLOT_OUT_W-1:0]      slot,
  output logic                       evicted,
  output logic [KEY_W-1:0]           evicted_key
);

  lksm_cmd_t cmd;

  // sequencing: capture, execute, result handshake
  lksm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // key table, recency ranks and result register
  lksm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .kind        (kind),
    .key         (key),
    .hit         (hit),
    .slot        (slot),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

endmodule

`default_nettype wire

/* tb/tb_lru_key_slot_map_unit.sv */
`default_nettype none

module tb_lru_key_slot_map_unit
  import lksm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Hard stop. The slowest legal run is about 2000 transactions, each with a
  // random sender gap, a random receiver stall and its pass through the block,
  // plus one long hold-off. That stays well under CYCLE_LIMIT.
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF    = 200;   // long receiver stall in the pressure test
  localparam int TAIL_CYCLES = 8;     // settle time after the last result

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [KEY_W-1:0]      evicted_key;
  } slot_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  kind = KIND_LOOKUP;
  logic [KEY_W-1:0]      key = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  evicted;
  logic [KEY_W-1:0]      evicted_key;

  // Mirror of the table: key per slot and recency rank per slot
  // (rank 0 = most recent, SLOTS-1 = next to be evicted).
  logic [KEY_W-1:0]  mirror_keys [SLOTS];
  logic [RANK_W-1:0] mirror_rank [SLOTS];

  // Answers predicted at request acceptance, oldest first.
  slot_answer_t slot_answers_q [$];

  // Idling switches, changed by the tests between stretches of traffic.
  bit source_idle = 1'b0;
  bit sink_idle   = 1'b0;
  int sink_hold_cycles = 0;   // one-off long stall, consumed by the sink

  int mismatch_count = 0;
  int results_seen   = 0;
  int n_lookups = 0, n_inserts = 0, n_hits = 0, n_evictions = 0;
  int cycle_count = 0;

  lru_key_slot_map_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .key         (key),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .slot        (slot),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table mirror
  // ---------------------------------------------------------------------------

  function automatic void reset_mirror();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      mirror_keys[i] = KEY_W'(KEY_BASE + i);
      mirror_rank[i] = RANK_W'(i);
    end
  endfunction

  // Move slot s to the front; everything that was more recent ages by one.
  function automatic void promote_slot(int s);
    int i;
    logic [RANK_W-1:0] r;
    r = mirror_rank[s];
    for (i = 0; i < SLOTS; i++) begin
      if (mirror_rank[i] < r) mirror_rank[i] = mirror_rank[i] + 1'b1;
    end
    mirror_rank[s] = '0;
  endfunction

  // Apply one request to the mirror and return the answer the block owes.
  function automatic slot_answer_t predict_table_access(logic req_kind,
                                                        logic [KEY_W-1:0] req_key);
    slot_answer_t ans;
    int i, found, victim;
    ans   = '0;
    found = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (found < 0 && mirror_keys[i] == req_key) found = i;
    end
    if (req_kind == KIND_LOOKUP) n_lookups++;
    else n_inserts++;

    if (found >= 0) begin
      // hit: lookups refresh recency, inserts of a present key touch nothing
      ans.hit  = 1'b1;
      ans.slot = SLOT_OUT_W'(found);
      n_hits++;
      if (req_kind == KIND_LOOKUP) promote_slot(found);
    end else if (req_kind == KIND_INSERT) begin
      // miss on insert: replace the oldest entry, lowest slot on a tie
      victim = 0;
      for (i = 1; i < SLOTS; i++) begin
        if (mirror_rank[i] > mirror_rank[victim]) victim = i;
      end
      ans.evicted     = 1'b1;
      ans.evicted_key = mirror_keys[victim];
      ans.slot        = SLOT_OUT_W'(victim);
      mirror_keys[victim] = req_key;
      promote_slot(victim);
      n_evictions++;
    end
    // lookup miss leaves every field at zero and the table untouched
    return ans;
  endfunction

  // Keys: about half drawn from the live table so hits and refreshes are
  // common, most of the rest from a band around the reset keys so evicted
  // keys come back, and a few anywhere in the byte range.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return mirror_keys[SLOT_W'($urandom_range(0, SLOTS - 1))];
    if (r < 85) return KEY_W'($urandom_range(40, 63));
    return KEY_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it. Valid is left
  // high so that a back-to-back transaction needs no second assignment in
  // the same time step; finish_phase lowers it.
  task automatic send_request(input logic req_kind, input logic [KEY_W-1:0] req_key);
    int gap;
    gap = source_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= req_kind;
    key       <= req_key;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    slot_answers_q.push_back(predict_table_access(req_kind, req_key));
  endtask

  // Stop offering and let every outstanding answer come back.
  task automatic finish_phase();
    req_valid <= 1'b0;
    while (slot_answers_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall driver and checker
  // ---------------------------------------------------------------------------

  // Per result transaction the sink draws a stall length before it will
  // accept; a pending long hold-off is added on top of that draw.
  initial begin : result_sink
    int wait_n;
    forever begin
      wait_n = sink_idle ? $urandom_range(0, 13) : 0;
      if (sink_hold_cycles > 0) begin
        wait_n += sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (wait_n > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid && sink_hold_cycles == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    slot_answer_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (slot_answers_q.size() == 0) begin
        $error("result with no request outstanding: slot %0d", slot);
        mismatch_count++;
      end else begin
        want = slot_answers_q.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          mismatch_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          mismatch_count++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted);
          mismatch_count++;
        end
        if (evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected 0x%02h, got 0x%02h",
                 want.evicted_key, evicted_key);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_count, slot_answers_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked transactions against the reset table, no idling.
  task automatic test_directed();
    source_idle = 1'b0;
    sink_idle   = 1'b0;
    // hits on the reset keys: most recent, least recent, middle
    send_request(KIND_LOOKUP, KEY_W'(KEY_BASE));
    send_request(KIND_LOOKUP, KEY_W'(KEY_BASE + SLOTS - 1));
    send_request(KIND_LOOKUP, KEY_W'(KEY_BASE + 4));
    // misses at both ends of the key range and just outside the reset band
    send_request(KIND_LOOKUP, 8'h00);
    send_request(KIND_LOOKUP, 8'hFF);
    send_request(KIND_LOOKUP, KEY_W'(KEY_BASE - 1));
    send_request(KIND_LOOKUP, KEY_W'(KEY_BASE + SLOTS));
    // insert of a present key: reports the slot, recency unchanged
    send_request(KIND_INSERT, KEY_W'(KEY_BASE + 1));
    send_request(KIND_INSERT, KEY_W'(KEY_BASE + SLOTS - 1));
    // new keys evict the oldest slots in turn
    send_request(KIND_INSERT, 8'h00);
    send_request(KIND_INSERT, 8'hFF);
    send_request(KIND_INSERT, 8'hAA);
    send_request(KIND_INSERT, 8'h55);
    // look up a key already evicted (a miss), evict two more, then hit two inserted keys
    send_request(KIND_LOOKUP, KEY_W'(KEY_BASE + 2));
    send_request(KIND_INSERT, 8'h80);
    send_request(KIND_INSERT, 8'h7F);
    send_request(KIND_LOOKUP, 8'hFF);
    send_request(KIND_LOOKUP, 8'h00);
    // enough inserts to wrap the whole table, then an evicted key misses
    send_request(KIND_INSERT, 8'h01);
    send_request(KIND_INSERT, 8'h02);
    send_request(KIND_INSERT, 8'h03);
    send_request(KIND_INSERT, 8'h04);
    send_request(KIND_LOOKUP, 8'hAA);
    send_request(KIND_INSERT, 8'h00);
    finish_phase();
  endtask

  // Random requests in blocks of 100, each block with its own idling mix:
  // none, sender only, receiver only, or both.
  task automatic test_random_traffic(input int n_items);
    int i, mode;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        mode        = $urandom_range(0, 3);
        source_idle = mode[0];
        sink_idle   = mode[1];
      end
      send_request(1'($urandom_range(0, 1)), pick_key());
    end
    finish_phase();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the block fills up and stalls its request side.
  task automatic test_result_backpressure();
    int i;
    source_idle      = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = HOLD_OFF;
    for (i = 0; i < 30; i++) send_request(1'($urandom_range(0, 1)), pick_key());
    finish_phase();
  endtask

  // Sender goes quiet until the block has answered everything, then resumes.
  task automatic test_quiet_gap();
    int i;
    source_idle = 1'b1;
    sink_idle   = 1'b1;
    for (i = 0; i < 10; i++) send_request(1'($urandom_range(0, 1)), pick_key());
    finish_phase();
    for (i = 0; i < 10; i++) send_request(1'($urandom_range(0, 1)), pick_key());
    finish_phase();
  endtask

  initial begin
    reset_mirror();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_result_backpressure();
    test_random_traffic(1880);
    test_quiet_gap();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests (%0d lookups, %0d inserts), %0d results checked",
             n_lookups + n_inserts, n_lookups, n_inserts, results_seen);
    $display("  %0d hits, %0d evictions, %0d field mismatches",
             n_hits, n_evictions, mismatch_count);
    if (mismatch_count == 0 && slot_answers_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
